// File: src/tgpw_pkg.sv
// tgpw_pkg: shared constants, widths and controller/datapath interface types
// for the text glyph page writer; no dependencies
`default_nettype none

package tgpw_pkg;

    // font and text geometry
    localparam int GLYPH_COUNT  = 95;
    localparam int TEXT_COLUMNS = 16;
    localparam int TEXT_ROWS    = 4;

    localparam int GLYPH_BYTES = 16;
    localparam int MEM_DEPTH   = GLYPH_COUNT * GLYPH_BYTES;
    localparam int GLYPH_W     = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int MEM_ADDR_W  = GLYPH_W + 4;

    // field widths
    localparam int FONT_ADDR_W = 11;
    localparam int CURSOR_W    = 5;
    localparam int COL_W       = 4;
    localparam int ROW_W       = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    // one run of bytes per character
    localparam int STEP_W      = 5;
    localparam int RUN_LEN     = 22;
    localparam int HALF_LEN    = 11;
    localparam int CMD_LEN     = 3;

    // controller command bytes
    localparam logic [7:0] CMD_PAGE   = 8'hb0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_COL_LO = 8'h02;
    localparam logic [7:0] NIBBLE_LO  = 8'h0f;
    localparam logic [7:0] NIBBLE_HI  = 8'hf0;

    // printable character range
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7e;

    // request kinds on s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef struct packed {
        logic write_font;
        logic start_draw;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic visible;
        logic out_free;
        logic at_last;
    } status_t;

endpackage

`default_nettype wire

// File: src/tgpw_ctrl.sv
// tgpw_ctrl: sequencing state machine of the text glyph page writer
// depends on tgpw_pkg
`default_nettype none

module tgpw_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           req_type,
    output logic                s_tready,
    input  wire tgpw_pkg::status_t status,
    output tgpw_pkg::cmd_t      cmd
);
    import tgpw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cmd.write_font = 1'b0;
        cmd.start_draw = 1'b0;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_type == REQ_DRAW) begin
                        cmd.start_draw = 1'b1;
                        state_next     = ST_CHECK;
                    end else begin
                        cmd.write_font = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                state_next = status.visible ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (status.out_free && status.at_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/tgpw_datapath.sv
// tgpw_datapath: glyph memory, cursor, step counter and output byte register
// depends on tgpw_pkg
`default_nettype none

module tgpw_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tgpw_pkg::cmd_t                cmd,
    output tgpw_pkg::status_t                  status,
    input  wire logic [tgpw_pkg::FONT_ADDR_W-1:0] font_address,
    input  wire logic [7:0]                    font_byte,
    input  wire logic [7:0]                    char_code,
    input  wire logic                          start_of_text,
    input  wire logic [tgpw_pkg::COL_W-1:0]    start_column,
    input  wire logic [tgpw_pkg::ROW_W-1:0]    text_row,
    input  wire logic                          mirrored,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tgpw_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);
    import tgpw_pkg::*;

    function automatic logic [7:0] flip_bits(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    logic [7:0]            glyph_mem [MEM_DEPTH];
    logic [7:0]            rd_data_reg;
    logic [MEM_ADDR_W-1:0] rd_addr;

    logic [CURSOR_W-1:0]   cursor_reg, cursor_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [GLYPH_W-1:0]    glyph_reg;
    logic [ROW_W-1:0]      row_reg;
    logic                  mir_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_tdata_reg;
    logic                  m_tuser_reg, m_tlast_reg;

    logic                  advance;
    logic [7:0]            glyph_num;
    logic [GLYPH_W-1:0]    glyph_sel;
    logic [ROW_W-1:0]      row_sat, row_sel;

    logic                  upper_n;
    logic [STEP_W-1:0]     off_n;
    logic [2:0]            idx_lo;

    logic                  upper;
    logic [STEP_W-1:0]     off;
    logic [COL_W-1:0]      col;
    logic [7:0]            px;
    logic [2:0]            page;
    logic [7:0]            byte_sel;
    logic                  data_sel;

    assign status.visible  = (cursor_reg < CURSOR_W'(TEXT_COLUMNS));
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.at_last  = (step_reg == STEP_W'(RUN_LEN - 1));
    assign advance         = cmd.emit && status.out_free;

    // glyph lookup for a new draw
    always_comb begin
        glyph_num = 8'd0;
        if (char_code >= CHAR_FIRST && char_code <= CHAR_LAST) begin
            glyph_num = char_code - CHAR_FIRST;
        end
        if ({1'b0, glyph_num} >= 9'(GLYPH_COUNT)) begin
            glyph_num = 8'd0;
        end
        glyph_sel = GLYPH_W'(glyph_num);
        row_sat   = ({1'b0, text_row} >= 3'(TEXT_ROWS)) ? ROW_W'(TEXT_ROWS - 1) : text_row;
        row_sel   = mirrored ? ROW_W'(TEXT_ROWS - 1) - row_sat : row_sat;
    end

    // step counter and cursor
    always_comb begin
        step_next   = step_reg;
        cursor_next = cursor_reg;
        if (cmd.start_draw) begin
            step_next = '0;
            if (start_of_text) begin
                cursor_next = CURSOR_W'(start_column);
            end
        end else if (advance) begin
            if (status.at_last) begin
                step_next   = '0;
                cursor_next = cursor_reg + CURSOR_W'(1);
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    // prefetch the glyph byte that the next step sends
    always_comb begin
        upper_n = (step_next < STEP_W'(HALF_LEN));
        off_n   = upper_n ? step_next : step_next - STEP_W'(HALF_LEN);
        idx_lo  = 3'(off_n - STEP_W'(CMD_LEN));
        rd_addr = {glyph_reg, (!upper_n) ^ mir_reg, mir_reg ? ~idx_lo : idx_lo};
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_font && ({1'b0, font_address} < 12'(MEM_DEPTH))) begin
            glyph_mem[MEM_ADDR_W'(font_address)] <= font_byte;
        end
        rd_data_reg <= glyph_mem[rd_addr];
    end

    // byte for the current step
    always_comb begin
        upper    = (step_reg < STEP_W'(HALF_LEN));
        off      = upper ? step_reg : step_reg - STEP_W'(HALF_LEN);
        col      = mir_reg ? COL_W'(TEXT_COLUMNS - 1) - cursor_reg[COL_W-1:0]
                           : cursor_reg[COL_W-1:0];
        px       = {1'b0, col, 3'b000};
        page     = {row_reg, !upper};
        data_sel = 1'b0;
        priority if (off == STEP_W'(0)) begin
            byte_sel = CMD_PAGE + {5'd0, page};
        end else if (off == STEP_W'(1)) begin
            byte_sel = CMD_COL_HI | ((px & NIBBLE_HI) >> 4);
        end else if (off == STEP_W'(2)) begin
            byte_sel = CMD_COL_LO | (px & NIBBLE_LO);
        end else begin
            byte_sel = mir_reg ? flip_bits(rd_data_reg) : rd_data_reg;
            data_sel = 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg   <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cursor_reg   <= cursor_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_draw) begin
            glyph_reg <= glyph_sel;
            row_reg   <= row_sel;
            mir_reg   <= mirrored;
        end
        if (advance) begin
            m_tdata_reg <= byte_sel;
            m_tuser_reg <= data_sel;
            m_tlast_reg <= status.at_last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

`default_nettype wire

// File: src/text_glyph_page_writer.sv
// text_glyph_page_writer: top level, joins the controller and the datapath
// depends on tgpw_pkg, tgpw_ctrl, tgpw_datapath
`default_nettype none

// channel  | direction | tdata                          | tuser    | tlast
// ---------+-----------+--------------------------------+----------+------------
// s_       | in        | font/char/position fields      | req_type | -
// m_       | out       | out_byte                       | is_data  | last_of_run
//
// a font load writes the byte to the glyph memory at accept
// a drawn character: accept, cursor check, then 22 bytes at one per cycle
// unless m_tready stalls, through the single output byte register
// a character past the last column returns to idle after the cursor check and sends nothing
// a stall on m_tready holds the step counter and the prefetched glyph byte
// reset clears the cursor, the sequencer and the output valid; the glyph memory
// holds no reset value and must be loaded before use

module text_glyph_page_writer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // font_address[10:0], font_byte[18:11], char_code[26:19], start_of_text[27],
    // start_column[31:28], text_row[33:32], mirrored[34], zero fill[39:35]
    input  wire logic [tgpw_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic [0:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_byte[7:0]
    output logic [tgpw_pkg::M_TDATA_W-1:0]      m_tdata,
    // is_data[0]
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast
);
    import tgpw_pkg::*;

    cmd_t    cmd;
    status_t status;

    // unpack the input transaction
    logic [FONT_ADDR_W-1:0] font_address;
    logic [7:0]             font_byte;
    logic [7:0]             char_code;
    logic                   start_of_text;
    logic [COL_W-1:0]       start_column;
    logic [ROW_W-1:0]       text_row;
    logic                   mirrored;

    assign font_address  = s_tdata[10:0];
    assign font_byte     = s_tdata[18:11];
    assign char_code     = s_tdata[26:19];
    assign start_of_text = s_tdata[27];
    assign start_column  = s_tdata[31:28];
    assign text_row      = s_tdata[33:32];
    assign mirrored      = s_tdata[34];

    // sequencer: idle, cursor check, byte emission
    tgpw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // glyph memory, cursor and output register
    tgpw_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .font_address  (font_address),
        .font_byte     (font_byte),
        .char_code     (char_code),
        .start_of_text (start_of_text),
        .start_column  (start_column),
        .text_row      (text_row),
        .mirrored      (mirrored),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

    // a draw transaction closes the input until its run is done
    a_draw_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == REQ_DRAW) |=> !s_tready)
        else $error("input open right after a draw transaction");

    // the last byte of a run reopens the input
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.out_free && status.at_last) |=> s_tready)
        else $error("input not reopened after the last byte");

    // the last byte of a run is always a glyph byte
    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("last byte of a run is a command");

    // no new draw while bytes are being emitted
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.write_font, cmd.start_draw, cmd.emit}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

// File: verif/tgpw_stream_checker.sv
// tgpw_stream_checker: watches both stream channels of the text glyph page writer,
// predicts the command/data bytes of every drawn character and compares them in order
// depends on tgpw_pkg
`default_nettype none

module tgpw_stream_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [tgpw_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]                     s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [tgpw_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]                     m_tuser,
    input  wire logic                           m_tlast,
    output int                                  mismatches,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tgpw_pkg::*;

    // s_tdata layout, highest field first
    typedef struct packed {
        logic [4:0]  fill;
        logic        mirrored;
        logic [1:0]  text_row;
        logic [3:0]  start_column;
        logic        start_of_text;
        logic [7:0]  char_code;
        logic [7:0]  font_byte;
        logic [10:0] font_address;
    } glyph_req_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
        logic       last;
    } page_byte_t;

    logic [7:0]          glyph_store [MEM_DEPTH];
    logic [CURSOR_W-1:0] cursor;
    page_byte_t          bytes_due [$];

    function automatic logic [7:0] mirror_bits(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[i] = v[7-i];
        return r;
    endfunction

    task automatic push_byte(input logic is_data, input logic [7:0] value, input logic last);
        page_byte_t e;
        e.is_data = is_data;
        e.value   = value;
        e.last    = last;
        bytes_due.push_back(e);
    endtask

    task automatic queue_position(input int col, input int page);
        logic [7:0] px;
        logic [7:0] pg;
        px = 8'(col * 8);
        pg = 8'(page);
        push_byte(1'b0, CMD_PAGE + pg, 1'b0);
        push_byte(1'b0, ((px & NIBBLE_HI) >> 4) | CMD_COL_HI, 1'b0);
        push_byte(1'b0, (px & NIBBLE_LO) | CMD_COL_LO, 1'b0);
    endtask

    task automatic render_char(input glyph_req_t r);
        int         glyph;
        int         col;
        int         row;
        int         idx;
        logic [7:0] b;
        if (r.start_of_text) cursor = CURSOR_W'(r.start_column);
        if (cursor >= TEXT_COLUMNS) return;
        glyph = 0;
        if (r.char_code >= CHAR_FIRST && r.char_code <= CHAR_LAST)
            glyph = r.char_code - CHAR_FIRST;
        if (glyph >= GLYPH_COUNT) glyph = 0;
        row = (r.text_row >= TEXT_ROWS) ? TEXT_ROWS - 1 : r.text_row;
        col = cursor;
        if (r.mirrored) begin
            col = TEXT_COLUMNS - 1 - col;
            row = TEXT_ROWS - 1 - row;
        end
        for (int half = 0; half < 2; half++) begin
            queue_position(col, row * 2 + half);
            for (int i = 0; i < 8; i++) begin
                // rotated text: lower glyph half goes first, bytes reversed
                if (r.mirrored) begin
                    idx = (1 - half) * 8 + 7 - i;
                    b = mirror_bits(glyph_store[glyph * GLYPH_BYTES + idx]);
                end else begin
                    idx = half * 8 + i;
                    b = glyph_store[glyph * GLYPH_BYTES + idx];
                end
                push_byte(1'b1, b, half == 1 && i == 7);
            end
        end
        cursor = cursor + CURSOR_W'(1);
    endtask

    always @(posedge aclk) begin : monitor
        glyph_req_t req;
        page_byte_t got;
        page_byte_t want;
        if (!aresetn) begin
            cursor = '0;
            bytes_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.is_data = m_tuser[0];
                got.value   = m_tdata;
                got.last    = m_tlast;
                if (bytes_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected byte is_data=%0d byte=%02h last=%0d",
                                 $realtime, got.is_data, got.value, got.last);
                    mismatches <= mismatches + 1;
                end else begin
                    want = bytes_due.pop_front();
                    if (got !== want) begin
                        // values listed as is_data, byte, last
                        if (mismatches < 10)
                            $display("%0t: mismatch expected %0d %02h %0d, got %0d %02h %0d",
                                     $realtime, want.is_data, want.value, want.last,
                                     got.is_data, got.value, got.last);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req = glyph_req_t'(s_tdata);
                if (s_tuser[0] == REQ_LOAD) begin
                    if (req.font_address < MEM_DEPTH)
                        glyph_store[req.font_address] = req.font_byte;
                end else begin
                    render_char(req);
                end
            end
            outstanding <= bytes_due.size();
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_text_glyph_page_writer.sv
// tb_text_glyph_page_writer: stimulus and verdict for the text glyph page writer
// depends on tgpw_pkg, text_glyph_page_writer and tgpw_stream_checker
`default_nettype none

module tb_text_glyph_page_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tgpw_pkg::*;

    // a slow correct run stays well under this limit, so it leaves a wide margin
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TOTAL_ITEMS  = 310;
    localparam int CALM_FROM    = 270;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int FONT_SPAN    = 2048;   // every value of the 11-bit address field
    localparam int FONT_GLYPHS  = 8;      // glyphs that get loaded and drawn

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    int mismatches;
    int outstanding;
    int cycles        = 0;
    int draws_offered = 0;
    int items_sent    = 0;
    bit calm          = 1'b0;   // no idling on either side near the end
    bit tx_gaps_on    = 1'b1;

    text_glyph_page_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tgpw_stream_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8 ns clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // font subset: only these glyphs are loaded, so draws stick to them;
    // glyph 0 also stands for every non-printable code
    // ---------------------------------------------------------------------
    function automatic logic [7:0] loaded_code(input int n);
        logic [7:0] c;
        case (n)
            0:       c = CHAR_FIRST;
            1:       c = "A";
            2:       c = "B";
            3:       c = "C";
            4:       c = "Z";
            5:       c = "0";
            6:       c = "a";
            default: c = CHAR_LAST;
        endcase
        return c;
    endfunction

    function automatic int glyph_base(input logic [7:0] code);
        return (int'(code) - int'(CHAR_FIRST)) * GLYPH_BYTES;
    endfunction

    // mostly loaded printable codes, sometimes a non-printable one
    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 7) != 0) return loaded_code($urandom_range(0, FONT_GLYPHS - 1));
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(127, 255));
    endfunction

    // ---------------------------------------------------------------------
    // sender side: one transaction per call, inputs move on the falling edge
    // ---------------------------------------------------------------------

    // valid low for a pause of length n
    task automatic pause(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // offer one transaction and hold it until the block takes it
    task automatic offer(input logic req, input logic [S_TDATA_W-1:0] payload);
        if (!calm && tx_gaps_on && $urandom_range(0, 4) == 0) pause($urandom_range(1, 11));
        items_sent++;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= payload;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic load_font(input int addr, input logic [7:0] value);
        logic [10:0] a;
        a = 11'(addr);
        offer(REQ_LOAD, {5'b0, 1'b0, 2'b0, 4'b0, 1'b0, 8'h00, value, a});
    endtask

    // unused load fields get random values to show they are ignored on draws
    task automatic draw_char(input logic [7:0] code, input logic start,
                             input logic [3:0] col, input logic [1:0] row, input logic mir);
        logic [10:0] junk_addr;
        logic [7:0]  junk_byte;
        junk_addr = 11'($urandom);
        junk_byte = 8'($urandom);
        draws_offered++;
        offer(REQ_DRAW, {5'b0, mir, row, col, start, code, junk_byte, junk_addr});
    endtask

    // ---------------------------------------------------------------------
    // receiver side: random stall bursts, plus one long hold-off so the
    // output register fills and s_tready has to drop
    // ---------------------------------------------------------------------
    initial begin : ready_side
        int gap;
        bit held;
        bit rx_gaps_on;
        gap        = 0;
        held       = 1'b0;
        rx_gaps_on = 1'b1;
        forever begin
            @(negedge aclk);
            if (($urandom & 127) == 0) rx_gaps_on = !rx_gaps_on;
            if (!held && draws_offered >= 30) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else if (gap == 0 && !calm && rx_gaps_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus and verdict
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int         choice;
        int         len;
        int         addr;
        logic [3:0] col;
        logic [1:0] row;
        logic       mir;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // load every glyph that is drawn later, so no draw reads an unwritten byte
        for (int g = 0; g < FONT_GLYPHS; g++) begin
            for (int bi = 0; bi < GLYPH_BYTES; bi++) begin
                load_font(glyph_base(loaded_code(g)) + bi, 8'($urandom_range(0, 255)));
            end
        end

        // directed: last font byte rewritten, addresses past the font ignored
        load_font(MEM_DEPTH - 1, 8'ha5);
        load_font(MEM_DEPTH, 8'hff);
        load_font(FONT_SPAN - 1, 8'h00);
        // top-left corner, first and last printable codes, non-printables
        draw_char(CHAR_LAST, 1'b1, 4'd0, 2'd0, 1'b0);
        draw_char(CHAR_FIRST, 1'b0, 4'd0, 2'd0, 1'b0);
        draw_char(8'h7f, 1'b0, 4'd0, 2'd1, 1'b0);
        draw_char(8'h00, 1'b0, 4'd0, 2'd1, 1'b0);
        draw_char(8'hff, 1'b0, 4'd0, 2'd2, 1'b0);
        draw_char(8'h1f, 1'b0, 4'd0, 2'd2, 1'b0);
        draw_char(8'h80, 1'b0, 4'd0, 2'd3, 1'b0);
        // last column, then the cursor runs off the end and draws are dropped
        draw_char("A", 1'b1, 4'd15, 2'd3, 1'b0);
        draw_char("B", 1'b0, 4'd15, 2'd3, 1'b0);
        draw_char("C", 1'b0, 4'd0, 2'd0, 1'b1);
        // rotated text at both corners and in the middle
        draw_char(CHAR_LAST, 1'b1, 4'd15, 2'd3, 1'b1);
        draw_char("A", 1'b1, 4'd0, 2'd0, 1'b1);
        draw_char(CHAR_LAST, 1'b1, 4'd5, 2'd2, 1'b1);
        draw_char("Z", 1'b0, 4'd9, 2'd1, 1'b1);

        // random: mostly lines of text, some font rewrites and stray draws
        while (items_sent < TOTAL_ITEMS) begin
            calm = (items_sent >= CALM_FROM);
            if ($urandom_range(0, 9) == 0) tx_gaps_on = !tx_gaps_on;
            choice = $urandom_range(0, 9);
            if (choice < 2) begin
                // font rewrite burst, now and then aimed past the font
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 7) == 0) begin
                        addr = $urandom_range(MEM_DEPTH, FONT_SPAN - 1);
                    end else begin
                        addr = glyph_base(loaded_code($urandom_range(0, FONT_GLYPHS - 1)))
                               + $urandom_range(0, GLYPH_BYTES - 1);
                    end
                    load_font(addr, 8'($urandom_range(0, 255)));
                end
            end else if (choice == 2) begin
                // draw that continues wherever the cursor happens to be
                draw_char(pick_code(), 1'b0, 4'($urandom), 2'($urandom), 1'($urandom));
            end else begin
                // a line of text, often starting near the right edge
                col = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 15));
                row = 2'($urandom);
                mir = 1'($urandom);
                len = $urandom_range(1, 20);
                for (int k = 0; k < len && items_sent < TOTAL_ITEMS; k++) begin
                    // start column only matters on the first character
                    draw_char(pick_code(), k == 0, (k == 0) ? col : 4'($urandom), row,
                              ($urandom_range(0, 15) == 0) ? !mir : mir);
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain every expected byte, then give the block time to misbehave
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
src/tgpw_pkg.sv
src/tgpw_ctrl.sv
src/tgpw_datapath.sv
src/text_glyph_page_writer.sv
verif/tgpw_stream_checker.sv
verif/tb_text_glyph_page_writer.sv
